// ===== design/mfps_pkg.sv =====
// shared types and constants for the median filtered pressure sensor
// no dependencies
package mfps_pkg;

  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned MEAN_W   = 16;
  localparam int unsigned PRESS_W  = 25;
  localparam int unsigned CFG_W    = 15;
  localparam int unsigned GAIN_W   = 14;
  localparam int unsigned ZERO_W   = 15;

  localparam logic [1:0] CFG_ADC_OFFSET = 2'd0;
  localparam logic [1:0] CFG_GAIN_CORR  = 2'd1;
  localparam logic [1:0] CFG_ZERO_CORR  = 2'd2;

  localparam logic [SAMPLE_W-1:0] OFFSET_RST = 12'd415;
  localparam logic [GAIN_W-1:0]   GAIN_RST   = 14'd100;

  localparam int signed   SCALE_MUL = 15000;
  localparam int signed   ZERO_MUL  = 64000;
  localparam int unsigned NUM_W     = 32;
  localparam int unsigned DEN_W     = 20;

  localparam logic signed [PRESS_W-1:0] P_MAX = 25'sh0FFFFFF;
  localparam logic signed [PRESS_W-1:0] P_MIN = 25'sh1000000;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic div_start;
    logic capture;
  } mfps_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic div_done;
  } mfps_sts_t;

endpackage

// ===== design/mfps_ctrl.sv =====
// controller state machine: sequences load, window scans and divisions
// depends on mfps_pkg
module mfps_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output mfps_pkg::mfps_cmd_t cmd,
  input  mfps_pkg::mfps_sts_t sts
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_DIVS, ST_DIVW, ST_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_start = 1'b1;
        state_nxt      = ST_DIVS;
      end
      ST_DIVS: begin
        if (sts.scan_done) begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIVW;
        end
      end
      ST_DIVW: begin
        if (sts.div_done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_nxt) begin
          cmd.capture   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == ST_SCAN) else $error("load left no scan");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r) else $error("result dropped");
  a_no_busy_accept: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> !cmd.load) else $error("load while busy");

endmodule

// ===== design/mfps_div.sv =====
// sequential restoring divider, unsigned magnitudes, one quotient bit per cycle
// depends on nothing
module mfps_div #(
  parameter int unsigned NW = 32,
  parameter int unsigned DW = 20
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] quo,
  output logic          done
);

  localparam int unsigned CW = $clog2(NW + 1);

  logic [NW-1:0] q_r, q_nxt;
  logic [DW:0]   rem_r, rem_nxt;
  logic [DW-1:0] den_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt, done_r, done_nxt;
  logic [DW:0]   trial;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[DW-1:0], q_r[NW-1]};
    if (start) begin
      q_nxt    = num;
      rem_nxt  = '0;
      cnt_nxt  = CW'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        q_nxt   = {q_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      den_r <= den;
    end
  end

  assign quo  = q_r;
  assign done = done_r;

endmodule

// ===== design/mfps_dp.sv =====
// datapath: sample ring, rank scan, trimmed sum, pressure numerator and dividers
// depends on mfps_pkg and mfps_div
module mfps_dp #(
  parameter int unsigned WINDOW = 20
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  mfps_pkg::mfps_cmd_t                   cmd,
  output mfps_pkg::mfps_sts_t                   sts,
  input  logic [mfps_pkg::SAMPLE_W-1:0]         in_sample,
  input  logic                                  cfg_we,
  input  logic [1:0]                            cfg_idx,
  input  logic [mfps_pkg::CFG_W-1:0]            cfg_data,
  output logic [mfps_pkg::SAMPLE_W-1:0]         out_median,
  output logic [mfps_pkg::MEAN_W-1:0]           out_trimmed_mean,
  output logic signed [mfps_pkg::PRESS_W-1:0]   out_pressure_milli,
  output logic                                  out_batch_end
);

  localparam int unsigned SW = mfps_pkg::SAMPLE_W;
  localparam int unsigned IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned CNW = $clog2(WINDOW + 1);
  localparam int unsigned NW = mfps_pkg::NUM_W;
  localparam int unsigned DW = mfps_pkg::DEN_W;
  localparam logic [CNW-1:0] RANK = CNW'(WINDOW / 2);

  typedef enum logic [1:0] {PH_IDLE, PH_RANK, PH_TRIM, PH_PRES} phase_t;

  logic [SW-1:0] win_r [WINDOW];
  logic [IW-1:0] slot_r;
  logic          last_r;

  logic [SW-1:0]                 offset_r;
  logic [mfps_pkg::GAIN_W-1:0]   gain_r;
  logic signed [mfps_pkg::ZERO_W-1:0] zero_r;

  phase_t        ph_r;
  logic [IW-1:0] i_r;
  logic [IW-1:0] j_r;
  logic [CNW-1:0] lt_r, le_r;
  logic [SW-1:0] med_r;
  logic          found_r;
  logic [SW+CNW-1:0] sum_r;
  logic [CNW-1:0] cnt_r;
  logic          scan_done_r;

  logic [SW-1:0] cand, elem;
  logic [SW:0]   diff;

  assign cand = win_r[i_r];
  assign elem = win_r[j_r];
  assign diff = (elem > med_r) ? {1'b0, elem - med_r} : {1'b0, med_r - elem};

  // calibrated numerator
  logic signed [NW-1:0] prod_a_r, prod_b_r, num_s;
  logic [NW-1:0]        num_mag_r;
  logic                 neg_r;
  logic [1:0]           pstep_r;
  logic                 zero_gain_r;

  logic [NW-1:0] q_mean, q_pres;
  logic          dn_mean, dn_pres;
  logic [NW-1:0] mean_num;
  logic          pdone_r;

  // result register
  logic [SW-1:0]                       median_r;
  logic [mfps_pkg::MEAN_W-1:0]         mean_r;
  logic signed [mfps_pkg::PRESS_W-1:0] press_r;
  logic                                batch_end_r;
  logic signed [mfps_pkg::PRESS_W-1:0] press_w;

  assign mean_num = NW'({sum_r, 4'b0000});
  assign num_s = prod_a_r - prod_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < WINDOW; k++) begin
        win_r[k] <= '0;
      end
      slot_r   <= '0;
      offset_r <= mfps_pkg::OFFSET_RST;
      gain_r   <= mfps_pkg::GAIN_RST;
      zero_r   <= '0;
      ph_r     <= PH_IDLE;
      scan_done_r <= 1'b0;
      pdone_r  <= 1'b0;
    end else begin
      scan_done_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_idx)
          mfps_pkg::CFG_ADC_OFFSET: offset_r <= cfg_data[SW-1:0];
          mfps_pkg::CFG_GAIN_CORR:  gain_r   <= cfg_data[mfps_pkg::GAIN_W-1:0];
          mfps_pkg::CFG_ZERO_CORR:  zero_r   <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.load) begin
        win_r[slot_r] <= in_sample;
        last_r <= (slot_r == IW'(WINDOW - 1));
        slot_r <= (slot_r == IW'(WINDOW - 1)) ? '0 : slot_r + 1'b1;
      end
      if (cmd.capture) begin
        median_r    <= med_r;
        mean_r      <= q_mean[mfps_pkg::MEAN_W-1:0];
        press_r     <= press_w;
        batch_end_r <= last_r;
      end
      if (cmd.div_start) begin
        pdone_r <= 1'b0;
      end else if (dn_pres) begin
        pdone_r <= 1'b1;
      end
      case (ph_r)
        PH_IDLE: begin
          if (cmd.scan_start) begin
            ph_r <= PH_RANK;
            i_r  <= '0;
            j_r  <= '0;
            lt_r <= '0;
            le_r <= '0;
            found_r <= 1'b0;
          end
        end
        PH_RANK: begin
          // candidate i has rank WINDOW/2 when lt <= rank < le
          if (j_r == IW'(WINDOW - 1)) begin
            if (!found_r && (CNW'(lt_r + (elem < cand)) <= RANK) &&
                (CNW'(le_r + (elem <= cand)) > RANK)) begin
              found_r <= 1'b1;
              med_r   <= cand;
            end
            lt_r <= '0;
            le_r <= '0;
            j_r  <= '0;
            if (i_r == IW'(WINDOW - 1)) begin
              ph_r  <= PH_TRIM;
              sum_r <= '0;
              cnt_r <= '0;
            end else begin
              i_r <= i_r + 1'b1;
            end
          end else begin
            lt_r <= lt_r + CNW'(elem < cand);
            le_r <= le_r + CNW'(elem <= cand);
            j_r  <= j_r + 1'b1;
          end
        end
        PH_TRIM: begin
          if (diff <= (SW+1)'(2)) begin
            sum_r <= sum_r + (SW+CNW)'(elem);
            cnt_r <= cnt_r + 1'b1;
          end
          if (j_r == IW'(WINDOW - 1)) begin
            ph_r    <= PH_PRES;
            pstep_r <= '0;
          end else begin
            j_r <= j_r + 1'b1;
          end
        end
        PH_PRES: begin
          pstep_r <= pstep_r + 1'b1;
          if (pstep_r == 2'd0) begin
            prod_a_r <= NW'((signed'({1'b0, med_r}) - signed'({1'b0, offset_r}))
                            * mfps_pkg::SCALE_MUL);
            prod_b_r <= NW'(zero_r * mfps_pkg::ZERO_MUL);
            zero_gain_r <= (gain_r == '0);
          end else begin
            neg_r     <= num_s[NW-1];
            num_mag_r <= num_s[NW-1] ? NW'(-num_s) : num_s;
            ph_r      <= PH_IDLE;
            scan_done_r <= 1'b1;
          end
        end
        default: ph_r <= PH_IDLE;
      endcase
    end
  end

  mfps_div #(.NW(NW), .DW(DW)) u_div_mean (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
    .num(mean_num), .den(DW'(cnt_r)), .quo(q_mean), .done(dn_mean)
  );

  mfps_div #(.NW(NW), .DW(DW)) u_div_pres (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
    .num(num_mag_r), .den({gain_r, 6'b000000}), .quo(q_pres), .done(dn_pres)
  );

  logic signed [NW:0] p_signed;
  always_comb begin
    p_signed = neg_r ? -signed'({1'b0, q_pres}) : signed'({1'b0, q_pres});
    if (zero_gain_r) begin
      press_w = '0;
    end else if (p_signed > (NW+1)'(mfps_pkg::P_MAX)) begin
      press_w = mfps_pkg::P_MAX;
    end else if (p_signed < (NW+1)'(mfps_pkg::P_MIN)) begin
      press_w = mfps_pkg::P_MIN;
    end else begin
      press_w = p_signed[mfps_pkg::PRESS_W-1:0];
    end
  end

  assign sts.scan_done = scan_done_r;
  assign sts.div_done  = dn_pres && dn_mean;
  assign out_median         = median_r;
  assign out_trimmed_mean   = mean_r;
  assign out_pressure_milli = press_r;
  assign out_batch_end      = batch_end_r;

  a_div_pair: assert property (@(posedge clk) disable iff (!rst_n)
    dn_pres |-> dn_mean) else $error("dividers out of step");
  a_trim_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    scan_done_r |-> cnt_r != '0) else $error("empty trimmed set");
  a_median_found: assert property (@(posedge clk) disable iff (!rst_n)
    scan_done_r |-> found_r) else $error("no median rank");
  a_pdone_hold: assert property (@(posedge clk) disable iff (!rst_n)
    pdone_r && !cmd.div_start |=> pdone_r) else $error("done lost");

endmodule

// ===== design/median_filtered_pressure_sensor_top.sv =====
// Each request runs from acceptance to out_valid through a rank count that compares every stored
// sample against every other, one compare a cycle, then a trimmed-sum pass over the ring, a
// registered numerator, two shift-subtract dividers run side by side, and handoff states between
// controller and datapath. One request is in work at a time; in_stall stays high until the result
// moves into the output register, so the next request can be taken in the same cycle that
// out_valid rises.
// depends on mfps_pkg, mfps_ctrl, mfps_dp
module median_filtered_pressure_sensor_top #(
  parameter int unsigned WINDOW = 20
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [mfps_pkg::SAMPLE_W-1:0]       in_sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [mfps_pkg::SAMPLE_W-1:0]       out_median,
  output logic [mfps_pkg::MEAN_W-1:0]         out_trimmed_mean,
  output logic signed [mfps_pkg::PRESS_W-1:0] out_pressure_milli,
  output logic                                out_batch_end,
  input  logic                                cfg_we,
  input  logic [1:0]                          cfg_idx,
  input  logic [mfps_pkg::CFG_W-1:0]          cfg_data
);

  mfps_pkg::mfps_cmd_t cmd;
  mfps_pkg::mfps_sts_t sts;

  mfps_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .sts(sts)
  );

  mfps_dp #(.WINDOW(WINDOW)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .in_sample(in_sample),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .out_median(out_median), .out_trimmed_mean(out_trimmed_mean),
    .out_pressure_milli(out_pressure_milli), .out_batch_end(out_batch_end)
  );

endmodule

// ===== tb/sv/tb_top.sv =====
// testbench for median_filtered_pressure_sensor_top: drives ADC samples, predicts the
// windowed median, trimmed mean and calibrated pressure per sample and compares every result
// depends on mfps_pkg and the median_filtered_pressure_sensor_top RTL
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIN = 20;
  localparam int LATENCY = WIN * WIN + WIN + 38;
  localparam logic [1:0] CFG_BAD_IDX = 2'd3;

  typedef struct {
    logic [mfps_pkg::SAMPLE_W-1:0] median;
    logic [mfps_pkg::MEAN_W-1:0]   mean;
    logic [mfps_pkg::PRESS_W-1:0]  press;
    logic                          last;
  } filt_res_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic [mfps_pkg::SAMPLE_W-1:0] in_sample = '0;
  logic out_valid;
  logic out_stall = 0;
  logic [mfps_pkg::SAMPLE_W-1:0] out_median;
  logic [mfps_pkg::MEAN_W-1:0] out_trimmed_mean;
  logic signed [mfps_pkg::PRESS_W-1:0] out_pressure_milli;
  logic out_batch_end;
  logic cfg_we = 0;
  logic [1:0] cfg_idx = '0;
  logic [mfps_pkg::CFG_W-1:0] cfg_data = '0;

  median_filtered_pressure_sensor_top #(.WINDOW(WIN)) i_dut (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  logic [mfps_pkg::SAMPLE_W-1:0] ring [WIN];
  int unsigned slot;
  logic [mfps_pkg::SAMPLE_W-1:0] offset_reg;
  logic [mfps_pkg::GAIN_W-1:0] gain_reg;
  logic [mfps_pkg::ZERO_W-1:0] zero_reg;

  logic [mfps_pkg::SAMPLE_W-1:0] sample_q[$];
  filt_res_t expected_q[$];
  int directed_q[$] = '{0, 4095, 4095, 0, 2048, 2049, 2050, 2046, 2047, 2052, 4095, 4095,
                        4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095, 1,
                        2730, 1365};
  int errors = 0;
  int gap_left = 0;
  int burst_left = 0;
  int long_hold = 0;
  int stall_phase = 0;

  function automatic filt_res_t filter_sample(logic [mfps_pkg::SAMPLE_W-1:0] s);
    filt_res_t r;
    int sorted [WIN];
    int tmp, med, sum, cnt, d;
    longint num, den, q, zc;
    ring[slot] = s;
    r.last = (slot == WIN - 1);
    slot = r.last ? 0 : slot + 1;
    for (int i = 0; i < WIN; i++) sorted[i] = ring[i];
    for (int i = 1; i < WIN; i++)
      for (int j = i; j > 0 && sorted[j-1] > sorted[j]; j--) begin
        tmp = sorted[j]; sorted[j] = sorted[j-1]; sorted[j-1] = tmp;
      end
    med = sorted[WIN/2];
    sum = 0;
    cnt = 0;
    for (int i = 0; i < WIN; i++) begin
      d = int'(ring[i]) - med;
      if (d <= 2 && d >= -2) begin
        sum += ring[i];
        cnt++;
      end
    end
    r.median = mfps_pkg::SAMPLE_W'(med);
    r.mean = mfps_pkg::MEAN_W'((cnt == 0) ? 0 : (sum * 16) / cnt);
    if (gain_reg == 0) q = 0;
    else begin
      zc = longint'($signed(zero_reg));
      num = (longint'(med) - longint'(offset_reg)) * 15000 - 64000 * zc;
      den = 64 * longint'(gain_reg);
      q = num / den;
      if (q > 16777215) q = 16777215;
      if (q < -16777216) q = -16777216;
    end
    r.press = q[mfps_pkg::PRESS_W-1:0];
    return r;
  endfunction

  // sender: bursts and gaps
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_q.push_back(filter_sample(in_sample));
        void'(sample_q.pop_front());
      end
      if (in_valid && in_stall) begin
      end else if (gap_left > 0) begin
        in_valid <= 0;
        gap_left <= gap_left - 1;
      end else if (sample_q.size() > 0) begin
        in_valid <= 1;
        in_sample <= sample_q[0];
        if (burst_left == 0) begin
          burst_left <= $urandom_range(12, 1);
          gap_left <= ($urandom_range(2) == 0) ? 0 : $urandom_range(700, 1);
        end else burst_left <= burst_left - 1;
      end else in_valid <= 0;
    end
  end

  // receiver: own stall pattern plus long hold-offs
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $display("%0t unexpected result median %0d", $realtime, out_median);
          errors++;
        end else begin
          filt_res_t e;
          e = expected_q.pop_front();
          if (out_median !== e.median) begin
            $display("%0t median exp %0d got %0d", $realtime, e.median, out_median);
            errors++;
          end
          if (out_trimmed_mean !== e.mean) begin
            $display("%0t trimmed_mean exp %0d got %0d", $realtime, e.mean, out_trimmed_mean);
            errors++;
          end
          if (out_pressure_milli !== e.press) begin
            $display("%0t pressure exp %0d got %0d", $realtime, $signed(e.press),
                     out_pressure_milli);
            errors++;
          end
          if (out_batch_end !== e.last) begin
            $display("%0t batch_end exp %0b got %0b", $realtime, e.last, out_batch_end);
            errors++;
          end
        end
      end
      stall_phase <= (stall_phase + 1) % 4000;
      if (long_hold > 0) begin
        long_hold <= long_hold - 1;
        out_stall <= 1;
      end else if (stall_phase == 1500) begin
        long_hold <= 3000;
        out_stall <= 1;
      end else if (stall_phase < 800) out_stall <= 0;
      else out_stall <= ($urandom_range(3) == 0);
    end
  end

  task automatic wait_drained();
    while (sample_q.size() != 0 || in_valid || expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [mfps_pkg::CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      mfps_pkg::CFG_ADC_OFFSET: offset_reg = val[mfps_pkg::SAMPLE_W-1:0];
      mfps_pkg::CFG_GAIN_CORR:  gain_reg = val[mfps_pkg::GAIN_W-1:0];
      mfps_pkg::CFG_ZERO_CORR:  zero_reg = val[mfps_pkg::ZERO_W-1:0];
      default: ;
    endcase
  endtask

  task automatic random_phase(int n);
    int base;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(4))
        0: sample_q.push_back(mfps_pkg::SAMPLE_W'($urandom));
        1: sample_q.push_back(mfps_pkg::SAMPLE_W'($urandom_range(4095, 4090)));
        2: sample_q.push_back(mfps_pkg::SAMPLE_W'($urandom_range(5)));
        default: begin
          base = $urandom_range(4091, 2);
          sample_q.push_back(mfps_pkg::SAMPLE_W'(base + int'($urandom_range(4)) - 2));
        end
      endcase
    end
  endtask

  initial begin
    foreach (ring[i]) ring[i] = '0;
    slot = 0;
    offset_reg = mfps_pkg::OFFSET_RST;
    gain_reg = mfps_pkg::GAIN_RST;
    zero_reg = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    // directed: extremes and near-median clusters
    foreach (directed_q[i]) sample_q.push_back(mfps_pkg::SAMPLE_W'(directed_q[i]));
    wait_drained();
    // zero gain and invalid index
    write_reg(mfps_pkg::CFG_GAIN_CORR, mfps_pkg::CFG_W'(0));
    write_reg(CFG_BAD_IDX, 15'h7FFF);
    random_phase(30);
    wait_drained();
    write_reg(mfps_pkg::CFG_GAIN_CORR, mfps_pkg::CFG_W'(1));
    write_reg(mfps_pkg::CFG_ADC_OFFSET, mfps_pkg::CFG_W'(0));
    write_reg(mfps_pkg::CFG_ZERO_CORR, 15'(-10000));
    random_phase(60);
    wait_drained();
    write_reg(mfps_pkg::CFG_ADC_OFFSET, mfps_pkg::CFG_W'(4095));
    write_reg(mfps_pkg::CFG_ZERO_CORR, 15'(10000));
    random_phase(60);
    wait_drained();
    write_reg(mfps_pkg::CFG_GAIN_CORR, mfps_pkg::CFG_W'(10000));
    write_reg(mfps_pkg::CFG_ZERO_CORR, 15'h7FFF);
    write_reg(mfps_pkg::CFG_ADC_OFFSET, mfps_pkg::CFG_W'(2048));
    random_phase(100);
    wait_drained();
    write_reg(mfps_pkg::CFG_GAIN_CORR, mfps_pkg::CFG_W'(16383));
    write_reg(mfps_pkg::CFG_ZERO_CORR, 15'h4000);
    random_phase(100);
    wait_drained();
    for (int k = 0; k < 4; k++) begin
      write_reg(mfps_pkg::CFG_ADC_OFFSET, mfps_pkg::CFG_W'($urandom_range(4095)));
      write_reg(mfps_pkg::CFG_GAIN_CORR, mfps_pkg::CFG_W'($urandom_range(10000, 1)));
      write_reg(mfps_pkg::CFG_ZERO_CORR, 15'($signed($urandom_range(20000)) - 10000));
      random_phase(110);
      wait_drained();
    end
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #1_000_000_000;
    $display("simulation failed");
    $finish;
  end
endmodule
